// ----- rtl/cpu8_pkg.sv -----
// Shared types, constants and a helper function for the cpu8 instruction step block.
package cpu8_pkg;

    localparam int MEM_DEPTH  = 65536;
    localparam int MEM_ADDR_W = $clog2(MEM_DEPTH);

    localparam logic [15:0] PROT_RESET = 16'h2000;
    localparam logic [16:0] WLIM_RESET = 17'h04000;

    localparam logic [2:0] RB = 3'd0;
    localparam logic [2:0] RC = 3'd1;
    localparam logic [2:0] RD = 3'd2;
    localparam logic [2:0] RE = 3'd3;
    localparam logic [2:0] RH = 3'd4;
    localparam logic [2:0] RL = 3'd5;

    localparam int FZ = 0;
    localparam int FC = 3;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_EXEC = 2'd1,
        OP_IRQ  = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic {
        CFG_PROTECTED_BELOW = 1'b0,
        CFG_WRITABLE_BELOW  = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_F0,
        S_F1,
        S_F2,
        S_F3,
        S_RD,
        S_RDW,
        S_EXEC,
        S_WR,
        S_RESP
    } t_state;

    typedef enum logic [2:0] {
        MEM_IDLE,
        MEM_LOAD,
        MEM_FETCH,
        MEM_READ,
        MEM_WRITE
    } t_mem_op;

    typedef enum logic [2:0] {
        CAP_NONE,
        CAP_OPC,
        CAP_B1,
        CAP_B2,
        CAP_D0,
        CAP_D1
    } t_cap;

    typedef struct packed {
        t_mem_op    mem;
        logic [1:0] idx;
        logic       exec;
        logic       load_out;
        logic       accept;
    } t_cmd;

    typedef struct packed {
        logic [1:0] n_rd;
        logic [1:0] n_wr;
        logic       out_free;
        logic       halted;
    } t_status;

    localparam logic [4:0] CYCLE_TABLE [256] = '{
        5'd4, 5'd10, 5'd7, 5'd5, 5'd5, 5'd5, 5'd7, 5'd4,
        5'd4, 5'd10, 5'd7, 5'd5, 5'd5, 5'd5, 5'd7, 5'd4,
        5'd4, 5'd10, 5'd7, 5'd5, 5'd5, 5'd5, 5'd7, 5'd4,
        5'd4, 5'd10, 5'd7, 5'd5, 5'd5, 5'd5, 5'd7, 5'd4,
        5'd4, 5'd10, 5'd16, 5'd5, 5'd5, 5'd5, 5'd7, 5'd4,
        5'd4, 5'd10, 5'd16, 5'd5, 5'd5, 5'd5, 5'd7, 5'd4,
        5'd4, 5'd10, 5'd13, 5'd5, 5'd10, 5'd10, 5'd10, 5'd4,
        5'd4, 5'd10, 5'd13, 5'd5, 5'd5, 5'd5, 5'd7, 5'd4,
        5'd5, 5'd5, 5'd5, 5'd5, 5'd5, 5'd5, 5'd7, 5'd5,
        5'd5, 5'd5, 5'd5, 5'd5, 5'd5, 5'd5, 5'd7, 5'd5,
        5'd5, 5'd5, 5'd5, 5'd5, 5'd5, 5'd5, 5'd7, 5'd5,
        5'd5, 5'd5, 5'd5, 5'd5, 5'd5, 5'd5, 5'd7, 5'd5,
        5'd5, 5'd5, 5'd5, 5'd5, 5'd5, 5'd5, 5'd7, 5'd5,
        5'd5, 5'd5, 5'd5, 5'd5, 5'd5, 5'd5, 5'd7, 5'd5,
        5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7,
        5'd5, 5'd5, 5'd5, 5'd5, 5'd5, 5'd5, 5'd7, 5'd5,
        5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd7, 5'd4,
        5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd7, 5'd4,
        5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd7, 5'd4,
        5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd7, 5'd4,
        5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd7, 5'd4,
        5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd7, 5'd4,
        5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd7, 5'd4,
        5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd7, 5'd4,
        5'd11, 5'd10, 5'd10, 5'd10, 5'd17, 5'd11, 5'd7, 5'd11,
        5'd11, 5'd10, 5'd10, 5'd10, 5'd10, 5'd17, 5'd7, 5'd11,
        5'd11, 5'd10, 5'd10, 5'd10, 5'd17, 5'd11, 5'd7, 5'd11,
        5'd11, 5'd10, 5'd10, 5'd10, 5'd10, 5'd17, 5'd7, 5'd11,
        5'd11, 5'd10, 5'd10, 5'd18, 5'd17, 5'd11, 5'd7, 5'd11,
        5'd11, 5'd5, 5'd10, 5'd5, 5'd17, 5'd17, 5'd7, 5'd11,
        5'd11, 5'd10, 5'd10, 5'd4, 5'd17, 5'd11, 5'd7, 5'd11,
        5'd11, 5'd5, 5'd10, 5'd4, 5'd17, 5'd17, 5'd7, 5'd11
    };

    // parity, sign, zero
    function automatic logic [2:0] zsp(input logic [7:0] v);
        zsp = {~^v, v[7], (v == 8'd0)};
    endfunction

endpackage

// ----- rtl/cpu8_if.sv -----
// Valid/ready channel interfaces for the item and result beats.
interface cpu8_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [15:0] load_address;
    logic [7:0]  load_data;
    logic [2:0]  interrupt_number;

    modport source (output valid, operation, load_address, load_data, interrupt_number,
                    input ready);
    modport sink   (input valid, operation, load_address, load_data, interrupt_number,
                    output ready);
endinterface

interface cpu8_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  cycles_used;
    logic [15:0] program_counter;
    logic [7:0]  accumulator;
    logic [4:0]  flag_bits;
    logic        write_refused;
    logic        stopped;

    modport source (output valid, cycles_used, program_counter, accumulator, flag_bits,
                    write_refused, stopped, input ready);
    modport sink   (input valid, cycles_used, program_counter, accumulator, flag_bits,
                    write_refused, stopped, output ready);
endinterface

// ----- rtl/cpu8_ram.sv -----
// Generic single-port RAM with registered read.
module cpu8_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_q <= r_mem[i_addr];
    end

    assign o_rdata = r_q;
endmodule

// ----- rtl/cpu8_ctrl.sv -----
// Sequencer: steps each item through those of load, fetch, operand read, execute, store and result that it needs.
module cpu8_ctrl import cpu8_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_operation,
    input  t_status    i_status,
    output t_cmd       o_cmd,
    output logic       o_in_ready
);
    t_state r_state, n_state;
    logic   r_idx, n_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        unique case (r_state)
            S_IDLE: begin
                n_idx = 1'b0;
                if (i_in_valid) begin
                    priority if (i_operation == OP_LOAD) begin
                        n_state = S_LOAD;
                    end else if (i_operation == OP_EXEC && !i_status.halted) begin
                        n_state = S_F0;
                    end else if (i_operation == OP_IRQ && !i_status.halted) begin
                        n_state = S_EXEC;
                    end else begin
                        n_state = S_RESP;
                    end
                end
            end
            S_LOAD: n_state = S_RESP;
            S_F0:   n_state = S_F1;
            S_F1:   n_state = S_F2;
            S_F2:   n_state = S_F3;
            S_F3: begin
                n_idx   = 1'b0;
                n_state = (i_status.n_rd != 2'd0) ? S_RD : S_EXEC;
            end
            S_RD: begin
                if ({1'b0, r_idx} == i_status.n_rd - 2'd1) begin
                    n_state = S_RDW;
                end else begin
                    n_idx = 1'b1;
                end
            end
            S_RDW: n_state = S_EXEC;
            S_EXEC: begin
                n_idx   = 1'b0;
                n_state = (i_status.n_wr != 2'd0) ? S_WR : S_RESP;
            end
            S_WR: begin
                if ({1'b0, r_idx} == i_status.n_wr - 2'd1) begin
                    n_state = S_RESP;
                end else begin
                    n_idx = 1'b1;
                end
            end
            S_RESP: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '{mem: MEM_IDLE, idx: 2'd0, exec: 1'b0, load_out: 1'b0, accept: 1'b0};
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            S_LOAD: o_cmd.mem = MEM_LOAD;
            S_F0: begin
                o_cmd.mem = MEM_FETCH;
                o_cmd.idx = 2'd0;
            end
            S_F1: begin
                o_cmd.mem = MEM_FETCH;
                o_cmd.idx = 2'd1;
            end
            S_F2: begin
                o_cmd.mem = MEM_FETCH;
                o_cmd.idx = 2'd2;
            end
            S_RD: begin
                o_cmd.mem = MEM_READ;
                o_cmd.idx = {1'b0, r_idx};
            end
            S_EXEC: o_cmd.exec = 1'b1;
            S_WR: begin
                o_cmd.mem = MEM_WRITE;
                o_cmd.idx = {1'b0, r_idx};
            end
            S_RESP: o_cmd.load_out = i_status.out_free;
            default: ;
        endcase
    end

    a_rd_has_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RD |-> i_status.n_rd != 2'd0)
        else $error("operand read issued with no read to do");

    a_wr_has_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WR |-> i_status.n_wr != 2'd0)
        else $error("store issued with no store to do");

    a_resp_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RESP && i_status.out_free |=> r_state == S_IDLE)
        else $error("result stage did not return to idle");
endmodule

// ----- rtl/cpu8_dp.sv -----
// Datapath: architectural registers, operand capture, instruction execute and result register.
module cpu8_dp import cpu8_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_idx,
    input  logic [16:0]           i_cfg_data,
    input  logic [1:0]            i_operation,
    input  logic [15:0]           i_load_address,
    input  logic [7:0]            i_load_data,
    input  logic [2:0]            i_interrupt_number,
    output logic                  o_mem_we,
    output logic [MEM_ADDR_W-1:0] o_mem_addr,
    output logic [7:0]            o_mem_wdata,
    input  logic [7:0]            i_mem_rdata,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [4:0]            o_cycles_used,
    output logic [15:0]           o_program_counter,
    output logic [7:0]            o_accumulator,
    output logic [4:0]            o_flag_bits,
    output logic                  o_write_refused,
    output logic                  o_stopped
);
    logic [7:0]  r_a, n_a;
    logic [7:0]  r_gp [6];
    logic [7:0]  n_gp [6];
    logic [15:0] r_sp, n_sp;
    logic [15:0] r_pc, n_pc;
    logic [4:0]  r_fl, n_fl;
    logic        r_ie, n_ie;
    logic        r_halt, n_halt;
    logic [4:0]  r_cycles, n_cycles;
    logic [15:0] r_wa0, n_wa0, r_wa1, n_wa1;
    logic [7:0]  r_wd0, n_wd0, r_wd1, n_wd1;
    logic [15:0] r_prot;
    logic [16:0] r_wlim;
    logic [1:0]  r_op;
    logic [15:0] r_ld_addr;
    logic [7:0]  r_ld_data;
    logic [2:0]  r_irq;
    logic [7:0]  r_opc, r_b1, r_b2, r_d0, r_d1;
    t_cap        r_cap, n_cap;
    logic        r_cap_zero;
    logic        r_refused;
    logic        r_ov;
    logic [4:0]  r_o_cyc;
    logic [15:0] r_o_pc;
    logic [7:0]  r_o_a;
    logic [4:0]  r_o_fl;
    logic        r_o_ref, r_o_stop;

    logic [15:0] imm, bc, de, hl, d16, ret16, rd_base, mem_addr;
    logic [16:0] sum17;
    logic [8:0]  t9;
    logic [7:0]  a1, x8, cap_data;
    logic [1:0]  n_rd, n_wr;
    logic        in_range, allowed, refuse_now;

    assign imm   = {r_b2, r_b1};
    assign bc    = {r_gp[RB], r_gp[RC]};
    assign de    = {r_gp[RD], r_gp[RE]};
    assign hl    = {r_gp[RH], r_gp[RL]};
    assign d16   = {r_d1, r_d0};
    assign ret16 = r_pc + 16'd3;

    always_comb begin
        n_rd    = 2'd0;
        n_wr    = 2'd0;
        rd_base = hl;
        unique case (r_opc)
            8'h0A: begin
                n_rd    = 2'd1;
                rd_base = bc;
            end
            8'h1A: begin
                n_rd    = 2'd1;
                rd_base = de;
            end
            8'h3A: begin
                n_rd    = 2'd1;
                rd_base = imm;
            end
            8'h2A: begin
                n_rd    = 2'd2;
                rd_base = imm;
            end
            8'h46, 8'h56, 8'h5E, 8'h66, 8'h7E, 8'hB6: n_rd = 2'd1;
            8'h34, 8'h35: begin
                n_rd = 2'd1;
                n_wr = 2'd1;
            end
            8'hC1, 8'hD1, 8'hE1, 8'hF1, 8'hC8, 8'hD8, 8'hC9: begin
                n_rd    = 2'd2;
                rd_base = r_sp;
            end
            8'h02, 8'h12, 8'h32, 8'h36, 8'h77: n_wr = 2'd1;
            8'h22, 8'hC5, 8'hD5, 8'hE5, 8'hF5, 8'hCD: n_wr = 2'd2;
            default: ;
        endcase
        if (r_op == OP_IRQ) begin
            n_rd = 2'd0;
            n_wr = 2'd2;
        end
    end

    assign o_status = '{n_rd: n_rd, n_wr: n_wr, out_free: (!r_ov || i_out_ready),
                        halted: r_halt};

    always_comb begin
        mem_addr = r_pc;
        o_mem_we = 1'b0;
        o_mem_wdata = r_wd0;
        n_cap = CAP_NONE;
        refuse_now = 1'b0;
        unique case (i_cmd.mem)
            MEM_LOAD: begin
                mem_addr    = r_ld_addr;
                o_mem_wdata = r_ld_data;
            end
            MEM_FETCH: begin
                mem_addr = r_pc + 16'(i_cmd.idx);
                unique case (i_cmd.idx)
                    2'd0:    n_cap = CAP_OPC;
                    2'd1:    n_cap = CAP_B1;
                    default: n_cap = CAP_B2;
                endcase
            end
            MEM_READ: begin
                mem_addr = rd_base + 16'(i_cmd.idx);
                n_cap    = i_cmd.idx[0] ? CAP_D1 : CAP_D0;
            end
            MEM_WRITE: begin
                mem_addr    = i_cmd.idx[0] ? r_wa1 : r_wa0;
                o_mem_wdata = i_cmd.idx[0] ? r_wd1 : r_wd0;
            end
            default: ;
        endcase
        in_range = ({1'b0, mem_addr} < 17'(MEM_DEPTH));
        allowed  = (mem_addr >= r_prot) && ({1'b0, mem_addr} < r_wlim) && in_range;
        if (i_cmd.mem == MEM_LOAD) begin
            o_mem_we = in_range;
        end else if (i_cmd.mem == MEM_WRITE) begin
            o_mem_we   = allowed;
            refuse_now = !allowed;
        end
    end

    assign o_mem_addr = mem_addr[MEM_ADDR_W-1:0];
    assign cap_data   = r_cap_zero ? 8'd0 : i_mem_rdata;

    always_comb begin
        n_a      = r_a;
        n_gp     = r_gp;
        n_sp     = r_sp;
        n_pc     = r_pc + 16'd1;
        n_fl     = r_fl;
        n_ie     = r_ie;
        n_halt   = r_halt;
        n_cycles = CYCLE_TABLE[r_opc];
        n_wa0    = hl;
        n_wa1    = hl;
        n_wd0    = r_a;
        n_wd1    = r_a;
        sum17    = 17'd0;
        t9       = 9'd0;
        a1       = 8'd0;
        x8       = 8'd0;
        if (r_op == OP_IRQ) begin
            n_cycles = 5'd0;
            n_wa0    = r_sp - 16'd1;
            n_wd0    = r_pc[15:8];
            n_wa1    = r_sp - 16'd2;
            n_wd1    = r_pc[7:0];
            n_sp     = r_sp - 16'd2;
            n_pc     = {10'd0, r_irq, 3'd0};
            n_ie     = 1'b0;
        end else begin
            unique case (r_opc)
                8'h00, 8'h08, 8'h10, 8'h18, 8'h20, 8'h28, 8'h30, 8'h38, 8'hD3, 8'hDB: ;
                8'h01: begin
                    n_gp[RB] = r_b2;
                    n_gp[RC] = r_b1;
                    n_pc     = ret16;
                end
                8'h11: begin
                    n_gp[RD] = r_b2;
                    n_gp[RE] = r_b1;
                    n_pc     = ret16;
                end
                8'h21: begin
                    n_gp[RH] = r_b2;
                    n_gp[RL] = r_b1;
                    n_pc     = ret16;
                end
                8'h31: begin
                    n_sp = imm;
                    n_pc = ret16;
                end
                8'h02: n_wa0 = bc;
                8'h12: n_wa0 = de;
                8'h03: {n_gp[RB], n_gp[RC]} = bc + 16'd1;
                8'h13: {n_gp[RD], n_gp[RE]} = de + 16'd1;
                8'h23: {n_gp[RH], n_gp[RL]} = hl + 16'd1;
                8'h33: n_sp = r_sp + 16'd1;
                8'h0B: {n_gp[RB], n_gp[RC]} = bc - 16'd1;
                8'h1B: {n_gp[RD], n_gp[RE]} = de - 16'd1;
                8'h2B: {n_gp[RH], n_gp[RL]} = hl - 16'd1;
                8'h04, 8'h0C, 8'h14, 8'h1C, 8'h24, 8'h2C: begin
                    x8 = r_gp[r_opc[5:3]] + 8'd1;
                    n_gp[r_opc[5:3]] = x8;
                    n_fl = {r_fl[4:3], zsp(x8)};
                end
                8'h05, 8'h0D, 8'h15, 8'h1D, 8'h25, 8'h2D: begin
                    x8 = r_gp[r_opc[5:3]] - 8'd1;
                    n_gp[r_opc[5:3]] = x8;
                    n_fl = {r_fl[4:3], zsp(x8)};
                end
                8'h3C: begin
                    n_a  = r_a + 8'd1;
                    n_fl = {r_fl[4:3], zsp(n_a)};
                end
                8'h3D: begin
                    n_a  = r_a - 8'd1;
                    n_fl = {r_fl[4:3], zsp(n_a)};
                end
                8'h34: begin
                    x8    = r_d0 + 8'd1;
                    n_fl  = {r_fl[4:3], zsp(x8)};
                    n_wd0 = x8;
                end
                8'h35: begin
                    x8    = r_d0 - 8'd1;
                    n_fl  = {r_fl[4:3], zsp(x8)};
                    n_wd0 = x8;
                end
                8'h06, 8'h0E, 8'h16, 8'h1E, 8'h26, 8'h2E: begin
                    n_gp[r_opc[5:3]] = r_b1;
                    n_pc = r_pc + 16'd2;
                end
                8'h3E: begin
                    n_a  = r_b1;
                    n_pc = r_pc + 16'd2;
                end
                8'h36: begin
                    n_wd0 = r_b1;
                    n_pc  = r_pc + 16'd2;
                end
                8'h07: begin
                    n_a  = {r_a[6:0], r_a[7]};
                    n_fl = {r_fl[4], r_a[7], r_fl[2:0]};
                end
                8'h0F: begin
                    n_a  = {r_a[0], r_a[7:1]};
                    n_fl = {r_fl[4], r_a[0], r_fl[2:0]};
                end
                8'h17: begin
                    n_a  = {r_a[6:0], r_fl[FC]};
                    n_fl = {r_fl[4], r_a[7], r_fl[2:0]};
                end
                8'h1F: begin
                    n_a  = {r_fl[FC], r_a[7:1]};
                    n_fl = {r_fl[4], r_a[0], r_fl[2:0]};
                end
                8'h09, 8'h19, 8'h29: begin
                    unique case (r_opc[5:4])
                        2'd0:    sum17 = {1'b0, hl} + {1'b0, bc};
                        2'd1:    sum17 = {1'b0, hl} + {1'b0, de};
                        default: sum17 = {1'b0, hl} + {1'b0, hl};
                    endcase
                    {n_gp[RH], n_gp[RL]} = sum17[15:0];
                    n_fl = {r_fl[4], sum17[16], r_fl[2:0]};
                end
                8'h0A, 8'h1A: n_a = r_d0;
                8'h22: begin
                    n_wa0 = imm;
                    n_wd0 = r_gp[RL];
                    n_wa1 = imm + 16'd1;
                    n_wd1 = r_gp[RH];
                    n_pc  = ret16;
                end
                8'h2A: begin
                    n_gp[RL] = r_d0;
                    n_gp[RH] = r_d1;
                    n_pc     = ret16;
                end
                8'h32: begin
                    n_wa0 = imm;
                    n_pc  = ret16;
                end
                8'h3A: begin
                    n_a  = r_d0;
                    n_pc = ret16;
                end
                8'h27: begin
                    a1 = (r_a[3:0] > 4'd9) ? r_a + 8'd6 : r_a;
                    n_a = a1;
                    if (a1[7:4] > 4'd9) begin
                        t9   = {1'b0, a1} + 9'h060;
                        n_a  = t9[7:0];
                        n_fl = {r_fl[4], t9[8], zsp(t9[7:0])};
                    end
                end
                8'h2F: n_a = ~r_a;
                8'h37: n_fl = {r_fl[4], 1'b1, r_fl[2:0]};
                8'h40, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45: n_gp[RB] = r_gp[r_opc[2:0]];
                8'h46: n_gp[RB] = r_d0;
                8'h47: n_gp[RB] = r_a;
                8'h4F: n_gp[RC] = r_a;
                8'h56: n_gp[RD] = r_d0;
                8'h57: n_gp[RD] = r_a;
                8'h5D: n_gp[RE] = r_gp[RL];
                8'h5E: n_gp[RE] = r_d0;
                8'h5F: n_gp[RE] = r_a;
                8'h66: n_gp[RH] = r_d0;
                8'h67: n_gp[RH] = r_a;
                8'h6F: n_gp[RL] = r_a;
                8'h77: ;
                8'h7A: n_a = r_gp[RD];
                8'h7B: n_a = r_gp[RE];
                8'h7C: n_a = r_gp[RH];
                8'h7D: n_a = r_gp[RL];
                8'h7E: n_a = r_d0;
                8'hA7: n_fl = {2'b00, zsp(r_a)};
                8'hAF: begin
                    n_a  = 8'd0;
                    n_fl = {2'b00, zsp(8'd0)};
                end
                8'hB0: begin
                    n_a  = r_a | r_gp[RB];
                    n_fl = {2'b00, zsp(n_a)};
                end
                8'hB6: begin
                    n_a  = r_a | r_d0;
                    n_fl = {2'b00, zsp(n_a)};
                end
                8'hE6: begin
                    n_a  = r_a & r_b1;
                    n_fl = {2'b00, zsp(n_a)};
                    n_pc = r_pc + 16'd2;
                end
                8'hC1: begin
                    {n_gp[RB], n_gp[RC]} = d16;
                    n_sp = r_sp + 16'd2;
                end
                8'hD1: begin
                    {n_gp[RD], n_gp[RE]} = d16;
                    n_sp = r_sp + 16'd2;
                end
                8'hE1: begin
                    {n_gp[RH], n_gp[RL]} = d16;
                    n_sp = r_sp + 16'd2;
                end
                8'hF1: begin
                    n_fl = r_d0[4:0];
                    n_a  = r_d1;
                    n_sp = r_sp + 16'd2;
                end
                8'hC5, 8'hD5, 8'hE5, 8'hF5, 8'hCD: begin
                    n_wa0 = r_sp - 16'd1;
                    n_wa1 = r_sp - 16'd2;
                    n_sp  = r_sp - 16'd2;
                    unique case (r_opc)
                        8'hC5:   {n_wd0, n_wd1} = bc;
                        8'hD5:   {n_wd0, n_wd1} = de;
                        8'hE5:   {n_wd0, n_wd1} = hl;
                        8'hF5:   {n_wd0, n_wd1} = {r_a, 3'b000, r_fl};
                        default: begin
                            {n_wd0, n_wd1} = ret16;
                            n_pc = imm;
                        end
                    endcase
                end
                8'hC3: n_pc = imm;
                8'hC2: n_pc = !r_fl[FZ] ? imm : ret16;
                8'hCA: n_pc = r_fl[FZ] ? imm : ret16;
                8'hD2: n_pc = !r_fl[FC] ? imm : ret16;
                8'hDA: n_pc = r_fl[FC] ? imm : ret16;
                8'hC6: begin
                    t9   = {1'b0, r_a} + {1'b0, r_b1};
                    n_a  = t9[7:0];
                    n_fl = {r_fl[4], t9[8], zsp(t9[7:0])};
                    n_pc = r_pc + 16'd2;
                end
                8'hC8, 8'hD8, 8'hC9: begin
                    if (r_opc == 8'hC9 || (r_opc == 8'hC8 && r_fl[FZ])
                            || (r_opc == 8'hD8 && r_fl[FC])) begin
                        n_pc = d16;
                        n_sp = r_sp + 16'd2;
                    end
                end
                8'hEB: begin
                    {n_gp[RD], n_gp[RE]} = hl;
                    {n_gp[RH], n_gp[RL]} = de;
                end
                8'hFB: n_ie = 1'b1;
                8'hFE: begin
                    x8   = r_a - r_b1;
                    n_fl = {r_fl[4], (r_a < r_b1), zsp(x8)};
                    n_pc = r_pc + 16'd2;
                end
                default: begin
                    n_pc     = r_pc;
                    n_halt   = 1'b1;
                    n_cycles = 5'd0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a       <= 8'd0;
            r_gp      <= '{default: 8'd0};
            r_sp      <= 16'd0;
            r_pc      <= 16'd0;
            r_fl      <= 5'd0;
            r_ie      <= 1'b0;
            r_halt    <= 1'b0;
            r_prot    <= PROT_RESET;
            r_wlim    <= WLIM_RESET;
            r_cap     <= CAP_NONE;
            r_refused <= 1'b0;
            r_cycles  <= 5'd0;
            r_ov      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_PROTECTED_BELOW: r_prot <= i_cfg_data[15:0];
                    CFG_WRITABLE_BELOW:  r_wlim <= i_cfg_data;
                endcase
            end
            r_cap <= n_cap;
            if (i_cmd.accept) begin
                r_refused <= 1'b0;
                r_cycles  <= 5'd0;
            end else if (refuse_now) begin
                r_refused <= 1'b1;
            end
            if (i_cmd.exec) begin
                r_a      <= n_a;
                r_gp     <= n_gp;
                r_sp     <= n_sp;
                r_pc     <= n_pc;
                r_fl     <= n_fl;
                r_ie     <= n_ie;
                r_halt   <= n_halt;
                r_cycles <= n_cycles;
            end
            if (i_cmd.load_out) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cap_zero <= !in_range;
        if (i_cmd.accept) begin
            r_op      <= i_operation;
            r_ld_addr <= i_load_address;
            r_ld_data <= i_load_data;
            r_irq     <= i_interrupt_number;
        end
        unique case (r_cap)
            CAP_OPC: r_opc <= cap_data;
            CAP_B1:  r_b1  <= cap_data;
            CAP_B2:  r_b2  <= cap_data;
            CAP_D0:  r_d0  <= cap_data;
            CAP_D1:  r_d1  <= cap_data;
            default: ;
        endcase
        if (i_cmd.exec) begin
            r_wa0 <= n_wa0;
            r_wa1 <= n_wa1;
            r_wd0 <= n_wd0;
            r_wd1 <= n_wd1;
        end
        if (i_cmd.load_out) begin
            r_o_cyc  <= r_cycles;
            r_o_pc   <= r_pc;
            r_o_a    <= r_a;
            r_o_fl   <= r_fl;
            r_o_ref  <= r_refused;
            r_o_stop <= r_halt;
        end
    end

    assign o_out_valid       = r_ov;
    assign o_cycles_used     = r_o_cyc;
    assign o_program_counter = r_o_pc;
    assign o_accumulator     = r_o_a;
    assign o_flag_bits       = r_o_fl;
    assign o_write_refused   = r_o_ref;
    assign o_stopped         = r_o_stop;

    a_halt_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt)
        else $error("stopped core resumed without reset");

    a_no_exec_halted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |-> !r_halt)
        else $error("execute issued while stopped");

    a_no_store_refused_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mem == MEM_WRITE && o_mem_we |-> allowed)
        else $error("store outside window reached memory");
endmodule

// ----- rtl/cpu8_instruction_step_top.sv -----
// Top level of the cpu8 instruction step block: sequencer, datapath and program memory.
// Each beat on the input is one operation on an 8-bit 8080-style core that owns its own program
// memory. A memory load passes through a load state and the result state. An instruction passes
// through three fetch states, a fetch wait, one read state per operand byte and a read wait when
// there are any, execute, one store state per byte stored and the result state; an interrupt
// through execute, the return address stores and the result state. The single shared memory port
// serves the fetch reads, the operand reads and the stores one at a time. A new beat is taken once
// the previous result has moved into the output register; that register holds while the sink stalls.
module cpu8_instruction_step_top import cpu8_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cpu8_in_if.sink       i_in,
    cpu8_out_if.source    o_out,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [16:0]   i_cfg_data
);
    t_cmd                  cmd;
    t_status               status;
    logic                  in_ready;
    logic                  mem_we;
    logic [MEM_ADDR_W-1:0] mem_addr;
    logic [7:0]            mem_wdata;
    logic [7:0]            mem_rdata;

    assign i_in.ready = in_ready;

    cpu8_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_operation (i_in.operation),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_ready  (in_ready)
    );

    cpu8_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_operation        (i_in.operation),
        .i_load_address     (i_in.load_address),
        .i_load_data        (i_in.load_data),
        .i_interrupt_number (i_in.interrupt_number),
        .o_mem_we           (mem_we),
        .o_mem_addr         (mem_addr),
        .o_mem_wdata        (mem_wdata),
        .i_mem_rdata        (mem_rdata),
        .o_out_valid        (o_out.valid),
        .i_out_ready        (o_out.ready),
        .o_cycles_used      (o_out.cycles_used),
        .o_program_counter  (o_out.program_counter),
        .o_accumulator      (o_out.accumulator),
        .o_flag_bits        (o_out.flag_bits),
        .o_write_refused    (o_out.write_refused),
        .o_stopped          (o_out.stopped)
    );

    cpu8_ram #(
        .WIDTH (8),
        .DEPTH (MEM_DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );
endmodule
